>>> hw/rtl/clb_pkg.sv
// ----------------------------------------------------------------------------
// clb_pkg
// Shared types and constants of the compacting list buffer: request and
// result field widths, opcodes, status codes and controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

package clb_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 9;

  typedef logic [OPCODE_W-1:0]       opcode_t;
  typedef logic [INDEX_W-1:0]        index_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [STATUS_W-1:0]       status_t;
  typedef logic [COUNT_W-1:0]        count_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND = 3'd0,
    OP_READ   = 3'd1,
    OP_UPDATE = 3'd2,
    OP_ERASE  = 3'd3,
    OP_COUNT  = 3'd4
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic    append;
    logic    update;
    logic    rd_index;
    logic    rd_erase;
    logic    rd_next;
    logic    shift_wr;
    logic    dec_count;
    logic    res_imm;
    logic    res_read;
    status_e res_status;
  } clb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_ok;
    logic full;
    logic erase_last;
    logic shift_last;
  } clb_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/clb_in_if.sv
// ----------------------------------------------------------------------------
// clb_in_if
// Request channel of the compacting list buffer: opcode, index and value.
// ----------------------------------------------------------------------------
`default_nettype none

interface clb_in_if;
  import clb_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  index_t  index;
  value_t  value;

  modport source (output valid, output opcode, output index, output value, input ready);
  modport sink   (input valid, input opcode, input index, input value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/clb_out_if.sv
// ----------------------------------------------------------------------------
// clb_out_if
// Result channel of the compacting list buffer: read value, status, count.
// ----------------------------------------------------------------------------
`default_nettype none

interface clb_out_if;
  import clb_pkg::*;

  logic    valid;
  logic    ready;
  value_t  read_value;
  status_t status;
  count_t  count;

  modport source (output valid, output read_value, output status, output count, input ready);
  modport sink   (input valid, input read_value, input status, input count, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/clb_datapath.sv
// ----------------------------------------------------------------------------
// clb_datapath
// Element memory, fill count, shift pointer and result payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module clb_datapath #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  clb_pkg::clb_cmd_t   cmd_i,
  output clb_pkg::clb_stat_t  stat_o,
  input  clb_pkg::index_t     index_i,
  input  clb_pkg::value_t     value_i,
  output clb_pkg::value_t     read_value_o,
  output clb_pkg::status_t    status_o,
  output clb_pkg::count_t     count_o
);
  import clb_pkg::*;

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];

  logic [CNT_W-1:0]             count_q, count_d;
  logic [AW-1:0]                ptr_q, ptr_d;
  logic signed [DATA_WIDTH-1:0] rdata_q;
  value_t                       res_value_q, res_value_d;
  status_t                      res_status_q, res_status_d;
  count_t                       res_count_q, res_count_d;

  logic [CMP_W-1:0]      idx_ext, cnt_ext;
  logic [AW-1:0]         idx_addr;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic                  re;
  logic [AW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] in_word;

  assign idx_ext  = CMP_W'(index_i);
  assign cnt_ext  = CMP_W'(count_q);
  assign idx_addr = AW'(idx_ext);
  assign in_word  = DATA_WIDTH'(value_i);

  assign stat_o.idx_ok     = idx_ext < cnt_ext;
  assign stat_o.full       = count_q == CNT_W'(DEPTH);
  assign stat_o.erase_last = (idx_ext + CMP_W'(1)) == cnt_ext;
  assign stat_o.shift_last = (CNT_W'(ptr_q) + CNT_W'(2)) == count_q;

  // memory write port
  always_comb begin
    we    = 1'b0;
    waddr = ptr_q;
    wdata = rdata_q;
    priority if (cmd_i.append) begin
      we    = 1'b1;
      waddr = AW'(count_q);
      wdata = in_word;
    end else if (cmd_i.update) begin
      we    = 1'b1;
      waddr = idx_addr;
      wdata = in_word;
    end else if (cmd_i.shift_wr) begin
      we    = 1'b1;
    end
  end

  // memory read port
  always_comb begin
    re    = 1'b0;
    raddr = idx_addr;
    priority if (cmd_i.rd_index) begin
      re    = 1'b1;
    end else if (cmd_i.rd_erase) begin
      re    = 1'b1;
      raddr = idx_addr + AW'(1);
    end else if (cmd_i.rd_next) begin
      re    = 1'b1;
      raddr = ptr_q + AW'(2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.append) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.dec_count) begin
      count_d = count_q - CNT_W'(1);
    end
    ptr_d = ptr_q;
    if (cmd_i.rd_erase) begin
      ptr_d = idx_addr;
    end else if (cmd_i.shift_wr) begin
      ptr_d = ptr_q + AW'(1);
    end
  end

  always_comb begin
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    res_count_d  = res_count_q;
    if (cmd_i.res_imm) begin
      res_value_d  = '0;
      res_status_d = cmd_i.res_status;
      res_count_d  = COUNT_W'(count_d);
    end else if (cmd_i.res_read) begin
      res_value_d  = VALUE_W'(rdata_q);
      res_status_d = ST_OK;
      res_count_d  = COUNT_W'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    res_count_q  <= res_count_d;
  end

  assign read_value_o = res_value_q;
  assign status_o     = res_status_q;
  assign count_o      = res_count_q;

endmodule

`default_nettype wire

>>> hw/rtl/clb_ctrl.sv
// ----------------------------------------------------------------------------
// clb_ctrl
// Request sequencer: decodes opcodes, steps the erase shift and owns the
// request and result handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module clb_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  clb_pkg::opcode_t    opcode_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  input  clb_pkg::clb_stat_t  stat_i,
  output clb_pkg::clb_cmd_t   cmd_o
);
  import clb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHIFT
  } state_e;

  state_e   state_q, state_d;
  logic     out_valid_q, out_valid_d;
  logic     accept;
  clb_cmd_t cmd;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    cmd            = '0;
    cmd.res_status = ST_OK;
    state_d        = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode_e'(opcode_i))
            OP_APPEND: begin
              cmd.res_imm = 1'b1;
              if (stat_i.full) begin
                cmd.res_status = ST_FULL;
              end else begin
                cmd.append = 1'b1;
              end
            end
            OP_READ: begin
              if (stat_i.idx_ok) begin
                cmd.rd_index = 1'b1;
                state_d      = S_READ;
              end else begin
                cmd.res_imm    = 1'b1;
                cmd.res_status = ST_INDEX;
              end
            end
            OP_UPDATE: begin
              cmd.res_imm = 1'b1;
              if (stat_i.idx_ok) begin
                cmd.update = 1'b1;
              end else begin
                cmd.res_status = ST_INDEX;
              end
            end
            OP_ERASE: begin
              priority if (!stat_i.idx_ok) begin
                cmd.res_imm    = 1'b1;
                cmd.res_status = ST_INDEX;
              end else if (stat_i.erase_last) begin
                cmd.res_imm   = 1'b1;
                cmd.dec_count = 1'b1;
              end else begin
                cmd.rd_erase = 1'b1;
                state_d      = S_SHIFT;
              end
            end
            default: begin
              cmd.res_imm = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.res_read = 1'b1;
        state_d      = S_IDLE;
      end
      S_SHIFT: begin
        cmd.shift_wr = 1'b1;
        if (stat_i.shift_last) begin
          cmd.dec_count = 1'b1;
          cmd.res_imm   = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || cmd.res_imm || cmd.res_read;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

`default_nettype wire

>>> hw/rtl/compacting_list_buffer_top.sv
// ----------------------------------------------------------------------------
// compacting_list_buffer_top
// Bounded ordered list of signed words with append, read, update, erase with
// compaction, and count query.
// ----------------------------------------------------------------------------
// Each request yields exactly one result. Append, update, count query, erase
// of the last element and any request rejected for a bad index or a full list
// register their result in the cycle they are accepted, so the block takes
// one request per cycle for them while the sink takes each result. A read
// passes through S_READ since the element memory has a registered read port.
// Other erases at index i read element i + 1, then in S_SHIFT the single
// memory port pair moves one later element down one place per cycle. A new
// request is taken in the cycle its predecessor's result is taken by the sink.
// Memory holds DEPTH words of DATA_WIDTH bits; no clearing pass after reset.
`default_nettype none

module compacting_list_buffer_top #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  clb_in_if.sink     in_if,
  clb_out_if.source  out_if
);
  import clb_pkg::*;

  clb_cmd_t  cmd;
  clb_stat_t stat;

  clb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .opcode_i    (in_if.opcode),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  clb_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .index_i      (in_if.index),
    .value_i      (in_if.value),
    .read_value_o (out_if.read_value),
    .status_o     (out_if.status),
    .count_o      (out_if.count)
  );

endmodule

`default_nettype wire
